// ===== rtl/pcvs_pkg.sv =====
// Package for the pulse count voice selector.
// Holds the mode and command codes and the queue control struct.
// Used by pcvs_queue and pulse_count_voice_selector.
package pcvs_pkg;

  // Mode of the selector, as reported on the mode output
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_SELECT = 2'd1,
    MODE_AWAIT  = 2'd2,
    MODE_STOP   = 2'd3
  } mode_e;

  // Command codes of the input channel; code three is unused
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_PLAY = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // Section number width and tick counter width
  localparam int unsigned SectionW = 8;
  localparam int unsigned CountW   = 10;

  // Control from the sequencer to the pending-section queue
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } q_ctl_t;

endpackage

// ===== rtl/pcvs_queue.sv =====
// FIFO of pending section numbers, built as a shift register.
// Head is always entry 0; a pop shifts every entry down by one.
// Depends on pcvs_pkg for the control struct and section width.
module pcvs_queue #(
  parameter int unsigned Depth = 20,
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pcvs_pkg::q_ctl_t                ctl_i,
  input  logic [pcvs_pkg::SectionW-1:0]   push_data_i,
  output logic [pcvs_pkg::SectionW-1:0]   head_o,
  output logic [CntW-1:0]                 fill_o,
  output logic                            full_o
);
  import pcvs_pkg::*;

  logic [SectionW-1:0] store_q [Depth];
  logic [SectionW-1:0] store_d [Depth];
  logic [CntW-1:0]     fill_q, fill_d;

  assign full_o = (fill_q == CntW'(Depth));
  assign head_o = store_q[0];
  assign fill_o = fill_q;

  // Entry update: write at the fill position, or shift toward the head
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      store_d[i] = store_q[i];
      if (ctl_i.push && !full_o && fill_q == CntW'(i)) begin
        store_d[i] = push_data_i;
      end else if (ctl_i.pop) begin
        if (i + 1 < Depth) begin
          store_d[i] = store_q[(i + 1) % Depth];
        end else begin
          store_d[i] = '0;
        end
      end
    end
  end

  // Fill count; entries at or above it are never read
  always_comb begin
    fill_d = fill_q;
    if (ctl_i.clear) begin
      fill_d = '0;
    end else if (ctl_i.push && !full_o) begin
      fill_d = fill_q + CntW'(1);
    end else if (ctl_i.pop && fill_q != '0) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Payload entries, no reset needed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      store_q[i] <= store_d[i];
    end
  end

endmodule

// ===== rtl/pulse_count_voice_selector.sv =====
// Pulse count voice selector: drives a voice chip's reset and data lines.
// Input channel (in_valid_i / in_stall_o) carries one command per transfer:
// a timer tick, a play request with a section number, or a stop request,
// plus the sampled busy pin of the chip. Output channel (out_valid_o /
// out_stall_i) returns one result per input transfer: the line levels,
// mode, current section, finished pulse, queue fill and timer state as
// they stand after that command.
// The result of an accepted transfer is registered and valid in the next
// cycle. Throughput is one item per cycle while the receiver does not stall;
// all sequencing is done by the state registers in a single pass, and the
// queue shifts all entries in parallel on a pop.
// While the receiver stalls, the result register holds and in_stall_o is
// raised so no further command is taken; a result being taken frees the
// register for a new transfer in the same cycle.
// Reset (rst_ni low, asynchronous) puts the block in idle with both lines
// low, the timer stopped and the queue empty. No clearing pass is needed.
// Depends on pcvs_pkg and pcvs_queue.
module pulse_count_voice_selector #(
  parameter int unsigned QUEUE_DEPTH = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         command_i,
  input  logic [pcvs_pkg::SectionW-1:0]      section_i,
  input  logic                               busy_pin_i,
  // Output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               reset_line_o,
  output logic                               data_line_o,
  output logic [1:0]                         mode_o,
  output logic [pcvs_pkg::SectionW-1:0]      current_section_o,
  output logic                               finished_o,
  output logic [$clog2(QUEUE_DEPTH + 1)-1:0] pending_count_o,
  output logic                               ticking_o
);
  import pcvs_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  mode_e               mode_q, mode_d;
  logic [SectionW-1:0] section_q, section_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                rst_lvl_q, rst_lvl_d;
  logic                dat_lvl_q, dat_lvl_d;
  logic                timer_q, timer_d;
  logic                fin_q, fin_d;
  logic                out_valid_q, out_valid_d;

  logic                acc;
  logic                idle_free;
  logic                play, stop_cmd, tick;
  logic                release_ev, sel_step, stop_step;
  logic                sel_done, stop_done;
  logic [CountW-1:0]   count_inc, sel_limit;

  q_ctl_t              q_ctl;
  logic [SectionW-1:0] q_head;
  logic [CntW-1:0]     q_fill;
  logic                q_full, q_empty;

  // Handshake: take a transfer whenever the result register is free
  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  // Command decode
  assign idle_free  = busy_pin_i && (mode_q == MODE_IDLE);
  assign play       = acc && (command_i == CMD_PLAY);
  assign stop_cmd   = acc && (command_i == CMD_STOP) && !idle_free;
  assign tick       = acc && (command_i == CMD_TICK) && timer_q;
  assign release_ev = tick && busy_pin_i && (mode_q == MODE_AWAIT);
  assign sel_step   = tick && (mode_q == MODE_SELECT);
  assign stop_step  = tick && (mode_q == MODE_STOP);
  assign q_empty    = (q_fill == '0);

  // Tick counter end points
  assign count_inc = count_q + CountW'(1);
  assign sel_limit = {1'b0, section_q, 1'b0} + CountW'(6);
  assign sel_done  = (count_inc >= sel_limit);
  assign stop_done = (count_inc >= CountW'(4));

  // Queue control
  assign q_ctl.push  = play && !idle_free && !q_full;
  assign q_ctl.pop   = release_ev && !q_empty;
  assign q_ctl.clear = stop_cmd;

  pcvs_queue #(
    .Depth (QUEUE_DEPTH),
    .CntW  (CntW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (q_ctl),
    .push_data_i (section_i),
    .head_o      (q_head),
    .fill_o      (q_fill),
    .full_o      (q_full)
  );

  // Next mode
  always_comb begin
    mode_d = mode_q;
    if (play && idle_free) begin
      mode_d = MODE_SELECT;
    end else if (stop_cmd) begin
      mode_d = MODE_STOP;
    end else if (release_ev) begin
      mode_d = q_empty ? MODE_IDLE : MODE_SELECT;
    end else if ((sel_step && sel_done) || (stop_step && stop_done)) begin
      mode_d = MODE_AWAIT;
    end
  end

  // Section, counter, line levels, timer and finished pulse
  always_comb begin
    section_d = section_q;
    count_d   = count_q;
    rst_lvl_d = rst_lvl_q;
    dat_lvl_d = dat_lvl_q;
    timer_d   = timer_q;
    fin_d     = 1'b0;
    if (play && idle_free) begin
      section_d = section_i;
      count_d   = '0;
      timer_d   = 1'b1;
    end else if (stop_cmd) begin
      section_d = '0;
      timer_d   = 1'b1;
      if (count_q >= CountW'(4)) begin
        count_d = '0;
      end
    end else if (release_ev) begin
      if (q_empty) begin
        section_d = '0;
        timer_d   = 1'b0;
        fin_d     = 1'b1;
      end else begin
        section_d = q_head;
        count_d   = '0;
      end
    end else if (sel_step) begin
      // reset pulse first, then data toggles from count four on
      if (count_q == CountW'(0)) begin
        rst_lvl_d = 1'b1;
        dat_lvl_d = 1'b0;
      end else if (count_q == CountW'(2)) begin
        rst_lvl_d = 1'b0;
      end else if (count_q >= CountW'(4)) begin
        dat_lvl_d = !dat_lvl_q;
      end
      count_d = count_inc;
      if (sel_done) begin
        count_d   = '0;
        rst_lvl_d = 1'b0;
        dat_lvl_d = 1'b0;
      end
    end else if (stop_step) begin
      // data low, then a reset pulse
      if (count_q == CountW'(0)) begin
        dat_lvl_d = 1'b0;
      end else if (count_q == CountW'(1)) begin
        rst_lvl_d = 1'b1;
      end else if (count_q == CountW'(3)) begin
        rst_lvl_d = 1'b0;
      end
      count_d = count_inc;
      if (stop_done) begin
        count_d   = '0;
        rst_lvl_d = 1'b0;
        dat_lvl_d = 1'b0;
      end
    end
  end

  // Result valid: set on a transfer in, cleared when the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and result registers; all but the valid flag only move on an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      section_q   <= '0;
      count_q     <= '0;
      rst_lvl_q   <= 1'b0;
      dat_lvl_q   <= 1'b0;
      timer_q     <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (acc) begin
        mode_q    <= mode_d;
        section_q <= section_d;
        count_q   <= count_d;
        rst_lvl_q <= rst_lvl_d;
        dat_lvl_q <= dat_lvl_d;
        timer_q   <= timer_d;
        fin_q     <= fin_d;
      end
    end
  end

  // Outputs straight from registers
  assign out_valid_o       = out_valid_q;
  assign reset_line_o      = rst_lvl_q;
  assign data_line_o       = dat_lvl_q;
  assign mode_o            = mode_q;
  assign current_section_o = section_q;
  assign finished_o        = fin_q;
  assign pending_count_o   = q_fill;
  assign ticking_o         = timer_q;

  // Checks
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> mode_q == MODE_IDLE && !timer_q && q_fill == '0)
    else $error("finished pulse without idle, stopped timer and empty queue");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_IDLE |-> !timer_q && section_q == '0)
    else $error("idle with timer running or section set");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_fill <= CntW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_stop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_STOP |-> count_q < CountW'(4))
    else $error("stop sequence count out of range");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(mode_q) && $stable(count_q) && $stable(q_fill))
    else $error("state changed while input stalled");

endmodule
